@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: lbl");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

`endif

@@ hw/rtl/mdtp_pkg.sv @@
// Types, codes and decode helpers for the method descriptor type parser.
`default_nettype none

package mdtp_pkg;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PARAMS = 3'd1,
    PH_CLASS  = 3'd2,
    PH_ARRAY  = 3'd3,
    PH_RETURN = 3'd4
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_PARAM  = 2'd0;
  localparam logic [1:0] KIND_RETURN = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Computational type codes.
  localparam logic [2:0] T_INT  = 3'd0;
  localparam logic [2:0] T_LONG = 3'd1;
  localparam logic [2:0] T_FLT  = 3'd2;
  localparam logic [2:0] T_DBL  = 3'd3;
  localparam logic [2:0] T_ADR  = 3'd4;
  localparam logic [2:0] T_VOID = 3'd5;

  // Descriptor characters.
  localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
  localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
  localparam logic [7:0] CH_LBRACK = 8'h5B; // '['
  localparam logic [7:0] CH_VOID   = 8'h56; // 'V'
  localparam logic [7:0] CH_CLASS  = 8'h4C; // 'L'
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_Z      = 8'h5A;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] type_code;
    logic [7:0] param_index;
    logic       last;
  } result_t;

  // Primitive type decode: ok is low for a character that is no primitive.
  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } prim_t;

  function automatic prim_t prim_type(input logic [7:0] c);
    prim_t p;
    p.ok   = 1'b1;
    p.code = T_INT;
    case (c)
      CH_B, CH_C, CH_I, CH_S, CH_Z: p.code = T_INT;
      CH_J:    p.code = T_LONG;
      CH_F:    p.code = T_FLT;
      CH_D:    p.code = T_DBL;
      default: p.ok   = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/method_descriptor_type_parser.sv @@
// Top level of the method descriptor type parser.
//
// Input channel: one descriptor character per transfer on ch, with start_req
// marking the leading character and is_static read on that same transfer.
// Output channel: at most one result per character (kind, type_code,
// param_index, last); a non-static start gives the implicit this address,
// each parameter gives its type, and the return type or an error ends the
// descriptor with last set and the parameter count in param_index.
// Each result is registered. Throughput is one character per cycle while
// in_stall is low: the decode is a single compare-and-select stage around
// the phase and count registers, followed by an output register and a
// one-entry skid register, so input keeps flowing while one result waits.
// When the receiver stalls, the skid register takes one more result and then
// in_stall rises until the output register drains.
// Reset (rst, synchronous) returns the parser to idle with a zero count and
// empties both result registers; characters before a start are dropped.
`default_nettype none
`include "assert_macros.svh"

module method_descriptor_type_parser #(
  parameter int MAX_PARAMS = 255
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  ch,
  input  wire        start_req,
  input  wire        is_static,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] kind,
  output logic [2:0] type_code,
  output logic [7:0] param_index,
  output logic       last
);

  localparam logic [7:0] MaxCount = 8'(MAX_PARAMS);

  mdtp_pkg::phase_t  phase, phase_next;
  logic [7:0]        param_count, param_count_next;
  logic [7:0]        count_sat;
  mdtp_pkg::prim_t   prim;
  mdtp_pkg::result_t res;
  logic              res_valid;
  mdtp_pkg::result_t out_q, skid;
  logic              skid_valid;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Shared decode of the current character.
  assign prim      = mdtp_pkg::prim_type(ch);
  assign count_sat = (param_count < MaxCount) ? param_count + 8'd1 : param_count;

  // Next phase and parameter count.
  always_comb begin
    phase_next       = phase;
    param_count_next = param_count;
    if (start_req) begin
      phase_next       = mdtp_pkg::PH_PARAMS;
      param_count_next = 8'd1;
      if (is_static) begin
        param_count_next = 8'd0;
      end
    end else begin
      case (phase)
        mdtp_pkg::PH_IDLE: begin
          phase_next = mdtp_pkg::PH_IDLE;
        end
        mdtp_pkg::PH_PARAMS: begin
          if (ch == mdtp_pkg::CH_RPAREN) begin
            phase_next = mdtp_pkg::PH_RETURN;
          end else if (ch == mdtp_pkg::CH_CLASS) begin
            phase_next       = mdtp_pkg::PH_CLASS;
            param_count_next = count_sat;
          end else if (ch == mdtp_pkg::CH_LBRACK) begin
            phase_next       = mdtp_pkg::PH_ARRAY;
            param_count_next = count_sat;
          end else if (!prim.ok) begin
            phase_next = mdtp_pkg::PH_IDLE;
          end else begin
            param_count_next = count_sat;
          end
        end
        mdtp_pkg::PH_CLASS: begin
          if (ch == mdtp_pkg::CH_SEMI) begin
            phase_next = mdtp_pkg::PH_PARAMS;
          end
        end
        mdtp_pkg::PH_ARRAY: begin
          if (ch == mdtp_pkg::CH_LBRACK) begin
            phase_next = mdtp_pkg::PH_ARRAY;
          end else if (ch == mdtp_pkg::CH_CLASS) begin
            phase_next = mdtp_pkg::PH_CLASS;
          end else if (!prim.ok) begin
            phase_next = mdtp_pkg::PH_IDLE;
          end else begin
            phase_next = mdtp_pkg::PH_PARAMS;
          end
        end
        mdtp_pkg::PH_RETURN: begin
          phase_next = mdtp_pkg::PH_IDLE;
        end
        default: begin
          phase_next = mdtp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result for the current character.
  always_comb begin
    res_valid         = 1'b0;
    res.kind          = mdtp_pkg::KIND_ERROR;
    res.type_code     = mdtp_pkg::T_INT;
    res.param_index   = param_count;
    res.last          = 1'b1;
    if (start_req) begin
      res_valid       = !is_static;
      res.kind        = mdtp_pkg::KIND_PARAM;
      res.type_code   = mdtp_pkg::T_ADR;
      res.param_index = 8'd0;
      res.last        = 1'b0;
    end else begin
      case (phase)
        mdtp_pkg::PH_PARAMS: begin
          if (ch == mdtp_pkg::CH_RPAREN) begin
            res_valid = 1'b0;
          end else if (ch == mdtp_pkg::CH_CLASS || ch == mdtp_pkg::CH_LBRACK) begin
            res_valid     = 1'b1;
            res.kind      = mdtp_pkg::KIND_PARAM;
            res.type_code = mdtp_pkg::T_ADR;
            res.last      = 1'b0;
          end else if (!prim.ok) begin
            res_valid = 1'b1;
          end else begin
            res_valid     = 1'b1;
            res.kind      = mdtp_pkg::KIND_PARAM;
            res.type_code = prim.code;
            res.last      = 1'b0;
          end
        end
        mdtp_pkg::PH_ARRAY: begin
          // Only a bad element character reports; the rest is skipped.
          res_valid = (ch != mdtp_pkg::CH_LBRACK) && (ch != mdtp_pkg::CH_CLASS) &&
                      !prim.ok;
        end
        mdtp_pkg::PH_RETURN: begin
          res_valid = 1'b1;
          if (ch == mdtp_pkg::CH_VOID) begin
            res.kind      = mdtp_pkg::KIND_RETURN;
            res.type_code = mdtp_pkg::T_VOID;
          end else if (ch == mdtp_pkg::CH_CLASS || ch == mdtp_pkg::CH_LBRACK) begin
            res.kind      = mdtp_pkg::KIND_RETURN;
            res.type_code = mdtp_pkg::T_ADR;
          end else if (prim.ok) begin
            res.kind      = mdtp_pkg::KIND_RETURN;
            res.type_code = prim.code;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mdtp_pkg::PH_IDLE;
      param_count <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      param_count <= param_count_next;
    end
  end

  // Output register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the result registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= skid_valid ? skid : res;
    end
    if (!skid_valid) begin
      skid <= res;
    end
  end

  assign kind        = out_q.kind;
  assign type_code   = out_q.type_code;
  assign param_index = out_q.param_index;
  assign last        = out_q.last;

  // Checks on the parser and the result buffering.
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_ALWAYS(a_count_bound, clk, rst, param_count <= MaxCount)
  `ASSERT_IMPLIES(a_last_ends, clk, rst, out_valid,
                  last == (kind != mdtp_pkg::KIND_PARAM))
  `ASSERT_IMPLIES(a_error_type, clk, rst, out_valid && kind == mdtp_pkg::KIND_ERROR,
                  type_code == mdtp_pkg::T_INT)

endmodule

`default_nettype wire
